### design/sntf_pkg.sv
package sntf_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int NAME_CHARS  = 64;
   localparam int IDX_W       = 8;
   localparam int CHR_W       = 6;
   localparam int LEN_W       = 7;
   localparam int CNT_W       = 9;

   localparam logic [7:0] CHR_NUL   = 8'h00;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_LOW_A = 8'h61;
   localparam logic [7:0] CHR_LOW_Z = 8'h7a;
   localparam logic [7:0] CASE_DIST = 8'h20;

   typedef struct packed {
      logic       kind;
      logic       fold_case;
      logic [7:0] name_char;
      logic       char_last;
   } req_type;

   typedef struct packed {
      logic             found;
      logic             inserted;
      logic             table_full;
      logic             name_cut;
      logic [7:0]       sorted_position;
      logic [CNT_W-1:0] symbol_number;
      logic [CNT_W-1:0] entry_total;
   } rsp_type;

   typedef struct packed {
      logic             kind;
      logic             cut;
      logic [LEN_W-1:0] len;
      logic             bank;
   } job_type;

   typedef struct packed {
      logic                en;
      logic [CHR_W:0]      addr;
      logic [7:0]          data;
   } key_wr_type;

endpackage

### design/sntf_ram.sv
module sntf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### design/sntf_front.sv
module sntf_front import sntf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_word,
   output key_wr_type key_wr,
   output logic       job_valid,
   output job_type    job,
   input  logic       job_pop
);

   // Two key banks; the bank being gathered is the queue write slot.
   logic [LEN_W-1:0] len_ff, len_in;
   logic             stopped_ff, stopped_in;
   logic             cut_ff, cut_in;
   job_type          q_ff [2];
   logic             wptr_ff, rptr_ff;
   logic [1:0]       cnt_ff, cnt_in;
   logic             accept, term, push_job;
   logic [7:0]       ch;

   assign req_full  = (cnt_ff == 2'd2);
   assign accept    = req_push && !req_full;
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rptr_ff];
   assign push_job  = accept && req_word.char_last;

   always_comb begin
      ch   = req_word.name_char;
      term = (ch == CHR_NUL) ||
             (req_word.fold_case && ((ch == CHR_SPACE) || (ch == CHR_TAB)));
      if (req_word.fold_case && ch >= CHR_LOW_A && ch <= CHR_LOW_Z) begin
         ch = ch - CASE_DIST;
      end
      len_in      = len_ff;
      stopped_in  = stopped_ff;
      cut_in      = cut_ff;
      key_wr.en   = 1'b0;
      key_wr.addr = {wptr_ff, len_ff[CHR_W-1:0]};
      key_wr.data = ch;
      if (accept && !stopped_ff) begin
         if (term) begin
            stopped_in = 1'b1;
         end else if (len_ff < LEN_W'(NAME_CHARS)) begin
            key_wr.en = 1'b1;
            len_in    = len_ff + 1'b1;
         end else begin
            cut_in = 1'b1;
         end
      end
      cnt_in = cnt_ff + {1'b0, push_job} - {1'b0, job_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         stopped_ff <= 1'b0;
         cut_ff     <= 1'b0;
         wptr_ff    <= 1'b0;
         rptr_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (job_pop) begin
            rptr_ff <= !rptr_ff;
         end
         if (push_job) begin
            q_ff[wptr_ff] <= '{kind: req_word.kind, cut: cut_in, len: len_in,
                               bank: wptr_ff};
            wptr_ff    <= !wptr_ff;
            len_ff     <= '0;
            stopped_ff <= 1'b0;
            cut_ff     <= 1'b0;
         end else begin
            len_ff     <= len_in;
            stopped_ff <= stopped_in;
            cut_ff     <= cut_in;
         end
      end
   end

endmodule

### design/sntf_back.sv
module sntf_back import sntf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  job_type          job,
   output logic             job_pop,
   output logic [CHR_W:0]   key_rd_addr,
   input  logic [7:0]       key_rd_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_word
);

   typedef enum logic [10:0] {
      S_IDLE      = 11'b00000000001,
      S_ORD_RD    = 11'b00000000010,
      S_ORD_WAIT  = 11'b00000000100,
      S_CMP_START = 11'b00000001000,
      S_CMP       = 11'b00000010000,
      S_MISS      = 11'b00000100000,
      S_SHIFT_RD  = 11'b00001000000,
      S_SHIFT_WR  = 11'b00010000000,
      S_INS_WR    = 11'b00100000000,
      S_COPY      = 11'b01000000000,
      S_DONE      = 11'b10000000000
   } state_type;

   state_type        state_ff, state_in;
   job_type          job_ff, job_in;
   logic [CNT_W-1:0] first_ff, first_in, end_ff, end_in, mid_ff, mid_in;
   logic [CNT_W-1:0] j_ff, j_in, count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CHR_W-1:0] c_ff, c_in;
   logic [LEN_W-1:0] k_ff, k_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic               ord_we, name_we;
   logic [IDX_W-1:0]   ord_wa, ord_wd, ord_ra, ord_rd;
   logic [IDX_W+CHR_W-1:0] name_wa, name_ra;
   logic [7:0]         name_wd, name_rd, kbyte;
   logic [CHR_W-1:0]   c_next, k_prev;
   logic [CNT_W-1:0]   nfirst, nend;
   logic [CNT_W:0]     msum;

   sntf_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_DEPTH)) u_order (
      .clock(clock), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
      .rd_addr(ord_ra), .rd_data(ord_rd)
   );

   sntf_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH * NAME_CHARS)) u_names (
      .clock(clock), .wr_en(name_we), .wr_addr(name_wa), .wr_data(name_wd),
      .rd_addr(name_ra), .rd_data(name_rd)
   );

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign c_next    = c_ff + 1'b1;
   assign k_prev    = CHR_W'(k_ff - 1'b1);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      first_in     = first_ff;
      end_in       = end_ff;
      mid_in       = mid_ff;
      j_in         = j_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      job_pop      = 1'b0;
      ord_we       = 1'b0;
      ord_wa       = mid_ff[IDX_W-1:0];
      ord_wd       = ord_rd;
      name_we      = 1'b0;
      name_wa      = {count_ff[IDX_W-1:0], k_prev};
      name_wd      = ({1'b0, k_prev} < job_ff.len) ? key_rd_data : 8'h00;
      nfirst       = first_ff;
      nend         = end_ff;
      msum         = '0;

      ord_ra  = (state_ff == S_SHIFT_RD) ? IDX_W'(j_ff - 1'b1) : mid_ff[IDX_W-1:0];
      name_ra = {idx_ff, (state_ff == S_CMP) ? c_next : CHR_W'(0)};
      if (state_ff == S_COPY) begin
         key_rd_addr = {job_ff.bank, k_ff[CHR_W-1:0]};
      end else if (state_ff == S_CMP) begin
         key_rd_addr = {job_ff.bank, c_next};
      end else begin
         key_rd_addr = {job_ff.bank, CHR_W'(0)};
      end
      kbyte = ({1'b0, c_ff} < job_ff.len) ? key_rd_data : 8'h00;

      // Common shape of a result; arms below adjust it.
      rsp_in.name_cut        = job_ff.cut;
      rsp_in.sorted_position = mid_ff[7:0];
      rsp_in.entry_total     = count_ff;

      // The job stays at the head of the queue until its result is written,
      // so the front never refills the key bank that is still being read.
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid && !rsp_valid_ff) begin
               job_in   = job;
               first_in = '0;
               end_in   = count_ff;
               mid_in   = count_ff >> 1;
               state_in = (count_ff != '0) ? S_ORD_RD : S_MISS;
            end
         end
         S_ORD_RD: begin
            state_in = S_ORD_WAIT;
         end
         S_ORD_WAIT: begin
            idx_in   = ord_rd;
            state_in = S_CMP_START;
         end
         S_CMP_START: begin
            c_in     = '0;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (name_rd != kbyte) begin
               if (name_rd < kbyte) begin
                  nend = mid_ff;
               end else begin
                  nfirst = mid_ff + 1'b1;
               end
               msum     = {1'b0, nfirst} + {1'b0, nend};
               first_in = nfirst;
               end_in   = nend;
               mid_in   = msum[CNT_W:1];
               state_in = (nfirst < nend) ? S_ORD_RD : S_MISS;
            end else if (name_rd == CHR_NUL || c_ff == CHR_W'(NAME_CHARS - 1)) begin
               rsp_in.found         = 1'b1;
               rsp_in.inserted      = 1'b0;
               rsp_in.table_full    = 1'b0;
               rsp_in.symbol_number = {1'b0, idx_ff} + 1'b1;
               rsp_valid_in         = 1'b1;
               job_pop              = 1'b1;
               state_in             = S_IDLE;
            end else begin
               c_in = c_next;
            end
         end
         S_MISS: begin
            rsp_in.found         = 1'b0;
            rsp_in.inserted      = 1'b0;
            rsp_in.table_full    = 1'b0;
            rsp_in.symbol_number = '0;
            if (job_ff.kind && count_ff < CNT_W'(TABLE_DEPTH)) begin
               j_in     = count_ff;
               state_in = (count_ff > mid_ff) ? S_SHIFT_RD : S_INS_WR;
            end else begin
               rsp_in.table_full = job_ff.kind;
               rsp_valid_in      = 1'b1;
               job_pop           = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_SHIFT_RD: begin
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            ord_we   = 1'b1;
            ord_wa   = j_ff[IDX_W-1:0];
            j_in     = j_ff - 1'b1;
            state_in = (j_ff - 1'b1 > mid_ff) ? S_SHIFT_RD : S_INS_WR;
         end
         S_INS_WR: begin
            ord_we   = 1'b1;
            ord_wd   = count_ff[IDX_W-1:0];
            k_in     = '0;
            state_in = S_COPY;
         end
         S_COPY: begin
            name_we = (k_ff != '0);
            if (k_ff == LEN_W'(NAME_CHARS)) begin
               count_in             = count_ff + 1'b1;
               rsp_in.inserted      = 1'b1;
               rsp_in.symbol_number = count_ff + 1'b1;
               rsp_in.entry_total   = count_ff + 1'b1;
               rsp_valid_in         = 1'b1;
               job_pop              = 1'b1;
               state_in             = S_IDLE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff   <= job_in;
      first_ff <= first_in;
      end_ff   <= end_in;
      mid_ff   <= mid_in;
      j_ff     <= j_in;
      idx_ff   <= idx_in;
      c_ff     <= c_in;
      k_ff     <= k_in;
      rsp_ff   <= rsp_in;
   end

endmodule

### design/sorted_name_table_find_insert.sv
// The front takes a character word while req_full is low; a search then makes up
// to 9 probes that read the order table and compare bytes, and an insert shifts
// later order entries up and copies the name; the front can gather the next name
// while the back is busy. Reset (synchronous, active high) empties the table and
// the key and result queues at once; name and order memories stay undefined, never cleared.
module sorted_name_table_find_insert import sntf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_word,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_word
);

   // The front gathers and folds characters into one of two key banks and
   // queues a job per name, so a second name can stream in while the back
   // searches the sorted table and inserts.
   key_wr_type     key_wr;
   logic           job_valid, job_pop;
   job_type        job;
   logic [CHR_W:0] key_rd_addr;
   logic [7:0]     key_rd_data;

   sntf_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_word(req_word), .key_wr(key_wr), .job_valid(job_valid), .job(job),
      .job_pop(job_pop)
   );

   // Key banks: bank select is the top address bit.
   sntf_ram #(.WIDTH(8), .DEPTH(2 * NAME_CHARS)) u_keys (
      .clock(clock), .wr_en(key_wr.en), .wr_addr(key_wr.addr),
      .wr_data(key_wr.data), .rd_addr(key_rd_addr), .rd_data(key_rd_data)
   );

   // The back runs the binary search with bytewise compares, the shifting
   // insert and the name copy, and holds the result word until it is popped.
   sntf_back u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job(job),
      .job_pop(job_pop), .key_rd_addr(key_rd_addr), .key_rd_data(key_rd_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_word(rsp_word)
   );

endmodule
